// File: hdl/pfe_pkg.sv
// Shared types and constants of the postfix expression evaluator.
package pfe_pkg;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } t_op;

    typedef struct packed {
        logic push;
        t_op  op;
        logic fin;
    } t_cmd;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNDER   = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

endpackage

// File: hdl/pfe_front.sv
// Character front end: number assembly and command classification.
module pfe_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_char_code,
    input  logic                   i_last,
    output logic                   o_ready,
    input  logic                   i_full,
    output logic                   o_wr,
    output pfe_pkg::t_cmd          o_cmd,
    output logic [VALUE_WIDTH-1:0] o_val
);

    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic                   r_in_num, n_in_num;
    logic                   accept;
    logic                   is_digit;
    logic [7:0]             dig;
    logic [VALUE_WIDTH-1:0] acc_next;
    pfe_pkg::t_op           op;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_digit = (i_char_code >= pfe_pkg::CH_0) && (i_char_code <= pfe_pkg::CH_9);
    assign dig      = i_char_code - pfe_pkg::CH_0;
    assign acc_next = (r_acc << 3) + (r_acc << 1) + VALUE_WIDTH'(dig[3:0]);

    always_comb begin
        unique case (i_char_code)
            pfe_pkg::CH_PLUS:  op = pfe_pkg::OP_ADD;
            pfe_pkg::CH_MINUS: op = pfe_pkg::OP_SUB;
            pfe_pkg::CH_STAR:  op = pfe_pkg::OP_MUL;
            pfe_pkg::CH_SLASH: op = pfe_pkg::OP_DIV;
            pfe_pkg::CH_PCT:   op = pfe_pkg::OP_MOD;
            default:           op = pfe_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_acc      = r_acc;
        n_in_num   = r_in_num;
        o_wr       = 1'b0;
        o_cmd.push = 1'b0;
        o_cmd.op   = pfe_pkg::OP_NONE;
        o_cmd.fin  = i_last;
        o_val      = r_acc;
        if (is_digit) begin
            o_val      = acc_next;
            o_cmd.push = i_last;
            if (accept) begin
                o_wr = i_last;
                if (i_last) begin
                    n_acc    = '0;
                    n_in_num = 1'b0;
                end else begin
                    n_acc    = acc_next;
                    n_in_num = 1'b1;
                end
            end
        end else begin
            o_cmd.push = r_in_num;
            o_cmd.op   = op;
            if (accept) begin
                o_wr     = r_in_num || (op != pfe_pkg::OP_NONE) || i_last;
                n_acc    = '0;
                n_in_num = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_in_num <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_in_num <= n_in_num;
        end
    end

endmodule

// File: hdl/pfe_queue.sv
// Short command queue between the front end and the execution unit.
module pfe_queue #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  pfe_pkg::t_cmd          i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_val,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_empty,
    output pfe_pkg::t_cmd          o_cmd,
    output logic [VALUE_WIDTH-1:0] o_val
);

    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    pfe_pkg::t_cmd          r_cmd_q [QD];
    logic [VALUE_WIDTH-1:0] r_val_q [QD];
    logic [QW-1:0]          r_wp, r_rp;
    logic [QW:0]            r_cnt;
    logic                   do_wr, do_rd;

    assign o_full  = (r_cnt == (QW+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_pop && !o_empty;
    assign o_cmd   = r_cmd_q[r_rp];
    assign o_val   = r_val_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_cmd_q[r_wp] <= i_cmd;
            r_val_q[r_wp] <= i_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hdl/pfe_back.sv
// Execution unit: operand stack, arithmetic sequencer and result register.
module pfe_back #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  pfe_pkg::t_cmd          i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_val,
    output logic                   o_pop,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_value,
    output logic [1:0]             o_status
);

    localparam int VW   = VALUE_WIDTH;
    localparam int IW   = $clog2(STACK_DEPTH);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int SW   = $clog2(VW + 1);
    localparam int MULN = (VW + 7) / 8;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OPRD = 7'b0000010,
        S_OPWT = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_FIX  = 7'b0100000,
        S_END  = 7'b1000000
    } t_state;

    logic [VW-1:0] r_mem [STACK_DEPTH];
    logic [VW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, rd_addr;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_err, n_err;
    logic [VW-1:0] r_tos, n_tos;
    pfe_pkg::t_op  r_op, n_op;
    logic          r_fin, n_fin;
    logic [VW-1:0] r_a, n_a, r_b, n_b, r_p, n_p;
    logic          r_nl, n_nl, r_nr, n_nr;
    logic [SW-1:0] r_step, n_step;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_value, n_out_value;
    logic [1:0]    r_out_status, n_out_status;

    logic [CW-1:0] cnt_m1, cnt_m2;
    logic [VW+7:0] mul_pp;
    logic [7:0]    mb_dig;
    logic [VW-1:0] mul_sum;
    logic [VW:0]   div_sh, div_df;
    logic [VW-1:0] lhs, rhs;
    t_state        done_state;

    assign cnt_m1     = r_count - CW'(1);
    assign cnt_m2     = r_count - CW'(2);
    assign mem_waddr  = cnt_m1[IW-1:0];
    assign rd_addr    = cnt_m2[IW-1:0];
    assign mb_dig     = r_b[7:0];
    assign mul_pp     = r_a * mb_dig;
    assign mul_sum    = r_p + mul_pp[VW-1:0];
    assign div_sh     = {r_p, r_a[VW-1]};
    assign div_df     = div_sh - {1'b0, r_b};
    assign lhs        = r_rd;
    assign rhs        = r_tos;
    assign done_state = r_fin ? S_END : S_IDLE;

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_tos;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_tos        = r_tos;
        n_op         = r_op;
        n_fin        = r_fin;
        n_a          = r_a;
        n_b          = r_b;
        n_p          = r_p;
        n_nl         = r_nl;
        n_nr         = r_nr;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        o_pop        = 1'b0;
        mem_we       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_op  = i_cmd.op;
                    n_fin = i_cmd.fin;
                    if (i_cmd.push && (r_err == pfe_pkg::ST_OK)) begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_err = pfe_pkg::ST_OVER;
                        end else begin
                            mem_we  = (r_count != '0);
                            n_tos   = i_val;
                            n_count = r_count + CW'(1);
                        end
                    end
                    if (i_cmd.op != pfe_pkg::OP_NONE) begin
                        n_state = S_OPRD;
                    end else if (i_cmd.fin) begin
                        n_state = S_END;
                    end
                end
            end
            S_OPRD: begin
                if (r_err != pfe_pkg::ST_OK) begin
                    n_state = done_state;
                end else if (r_count < CW'(2)) begin
                    n_err   = pfe_pkg::ST_UNDER;
                    n_state = done_state;
                end else begin
                    n_state = S_OPWT;
                end
            end
            S_OPWT: begin
                n_p    = '0;
                n_step = '0;
                case (r_op)
                    pfe_pkg::OP_ADD: begin
                        n_tos   = lhs + rhs;
                        n_count = cnt_m1;
                        n_state = done_state;
                    end
                    pfe_pkg::OP_SUB: begin
                        n_tos   = lhs - rhs;
                        n_count = cnt_m1;
                        n_state = done_state;
                    end
                    pfe_pkg::OP_MUL: begin
                        n_a     = lhs;
                        n_b     = rhs;
                        n_state = S_MUL;
                    end
                    pfe_pkg::OP_DIV, pfe_pkg::OP_MOD: begin
                        if (rhs == '0) begin
                            n_err   = pfe_pkg::ST_DIVZERO;
                            n_count = cnt_m2;
                            n_state = done_state;
                        end else begin
                            n_nl    = lhs[VW-1];
                            n_nr    = rhs[VW-1];
                            n_a     = lhs[VW-1] ? (-lhs) : lhs;
                            n_b     = rhs[VW-1] ? (-rhs) : rhs;
                            n_state = S_DIV;
                        end
                    end
                    default: n_state = done_state;
                endcase
            end
            S_MUL: begin
                n_p    = mul_sum;
                n_a    = r_a << 8;
                n_b    = r_b >> 8;
                n_step = r_step + SW'(1);
                if (r_step == SW'(MULN - 1)) begin
                    n_tos   = mul_sum;
                    n_count = cnt_m1;
                    n_state = done_state;
                end
            end
            S_DIV: begin
                if (!div_df[VW]) begin
                    n_p = div_df[VW-1:0];
                    n_a = {r_a[VW-2:0], 1'b1};
                end else begin
                    n_p = div_sh[VW-1:0];
                    n_a = {r_a[VW-2:0], 1'b0};
                end
                n_step = r_step + SW'(1);
                if (r_step == SW'(VW - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                if (r_op == pfe_pkg::OP_DIV) begin
                    n_tos = (r_nl ^ r_nr) ? (-r_a) : r_a;
                end else begin
                    n_tos = r_nl ? (-r_p) : r_p;
                end
                n_count = cnt_m1;
                n_state = done_state;
            end
            S_END: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_err;
                    n_out_value  = '0;
                    if (r_err == pfe_pkg::ST_OK) begin
                        if (r_count == '0) begin
                            n_out_status = pfe_pkg::ST_UNDER;
                        end else begin
                            n_out_value = 32'(signed'(r_tos));
                        end
                    end
                    n_count = '0;
                    n_err   = pfe_pkg::ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= pfe_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_op         <= n_op;
        r_fin        <= n_fin;
        r_a          <= n_a;
        r_b          <= n_b;
        r_p          <= n_p;
        r_nl         <= n_nl;
        r_nr         <= n_nr;
        r_step       <= n_step;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

endmodule

// File: hdl/postfix_expression_evaluator_top.sv
// Top level of the postfix expression evaluator.
//
// Input channel (i_valid / o_ready) takes one ASCII character word per
// cycle with i_last marking the final character of an expression. Output
// channel (o_valid / i_ready) delivers one word per expression: o_value,
// the top of the operand stack, and o_status (0 ok, 1 underflow,
// 2 divide by zero, 3 overflow).
// The front end takes a character every cycle while its 4-entry command
// queue has room. The execution unit handles a push in its idle state.
// Operators go through operand read and wait states, where + and -
// finish; * then loops on an 8-bit digit multiplier, and / or % runs a
// restoring divider (one quotient bit per cycle) and a sign fix-up
// state. An end state posts the result to the output register.
// The stack is a STACK_DEPTH-entry memory with one write and one
// registered read port; the top entry is kept in a register.
// Reset empties the stack, clears the error status and drops any partial
// number. When the receiver stalls, the result waits in the output
// register; execution stops at the next end of expression and the queue,
// then the input channel, back up.
module postfix_expression_evaluator_top #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status
);

    logic                   q_wr, q_full, q_pop, q_empty;
    pfe_pkg::t_cmd          f_cmd, q_cmd;
    logic [VALUE_WIDTH-1:0] f_val, q_val;

    pfe_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_ready     (o_ready),
        .i_full      (q_full),
        .o_wr        (q_wr),
        .o_cmd       (f_cmd),
        .o_val       (f_val)
    );

    pfe_queue #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_cmd   (f_cmd),
        .i_val   (f_val),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd),
        .o_val   (q_val)
    );

    pfe_back #(
        .STACK_DEPTH(STACK_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (q_cmd),
        .i_val    (q_val),
        .o_pop    (q_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the postfix expression evaluator.
module tb;

    localparam int         DEPTH    = 16;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       drain;
    } t_char_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_last      = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_value;
    logic [1:0]  o_status;

    t_char_word  pending_chars[$];
    logic [31:0] want_value[$];
    logic [1:0]  want_status[$];

    logic [31:0] calc_stack [DEPTH];
    int          calc_depth  = 0;
    logic [31:0] calc_acc    = 32'd0;
    logic        calc_in_num = 1'b0;
    logic [1:0]  calc_err    = pfe_pkg::ST_OK;

    int          char_total     = 0;
    int          chars_accepted = 0;
    int          results_seen   = 0;
    int          mismatches     = 0;

    t_char_word  next_word;
    logic        send_now;
    int          burst_left = 0;
    int          gap_left   = 0;

    int          hold_left      = 0;
    logic        long_hold_done = 1'b0;
    int          rx_mode        = 0;
    int          rx_phase       = 0;
    logic        ready_now;
    logic [31:0] exp_v;
    logic [1:0]  exp_s;

    postfix_expression_evaluator_top #(
        .STACK_DEPTH(DEPTH),
        .VALUE_WIDTH(32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    always #1 i_clk = ~i_clk;

    task automatic calc_push(input logic [31:0] v);
        if (calc_err != pfe_pkg::ST_OK) return;
        if (calc_depth >= DEPTH) begin
            calc_err = pfe_pkg::ST_OVER;
            return;
        end
        calc_stack[calc_depth] = v;
        calc_depth++;
    endtask

    task automatic calc_char(input logic [7:0] c, input logic fin);
        pfe_pkg::t_op op;
        logic [31:0]  l, r, ml, mr, q, res, top;
        logic [1:0]   st;
        case (c)
            pfe_pkg::CH_PLUS:  op = pfe_pkg::OP_ADD;
            pfe_pkg::CH_MINUS: op = pfe_pkg::OP_SUB;
            pfe_pkg::CH_STAR:  op = pfe_pkg::OP_MUL;
            pfe_pkg::CH_SLASH: op = pfe_pkg::OP_DIV;
            pfe_pkg::CH_PCT:   op = pfe_pkg::OP_MOD;
            default:           op = pfe_pkg::OP_NONE;
        endcase
        if (c >= pfe_pkg::CH_0 && c <= pfe_pkg::CH_9) begin
            calc_acc    = calc_acc * 32'd10 + 32'(c - pfe_pkg::CH_0);
            calc_in_num = 1'b1;
        end else begin
            if (calc_in_num) begin
                calc_push(calc_acc);
                calc_acc    = 32'd0;
                calc_in_num = 1'b0;
            end
            if (op != pfe_pkg::OP_NONE && calc_err == pfe_pkg::ST_OK) begin
                if (calc_depth < 2) begin
                    calc_err = pfe_pkg::ST_UNDER;
                end else begin
                    r = calc_stack[calc_depth-1];
                    l = calc_stack[calc_depth-2];
                    calc_depth -= 2;
                    if (op == pfe_pkg::OP_DIV || op == pfe_pkg::OP_MOD) begin
                        if (r == 32'd0) begin
                            calc_err = pfe_pkg::ST_DIVZERO;
                        end else begin
                            ml = l[31] ? 32'd0 - l : l;
                            mr = r[31] ? 32'd0 - r : r;
                            if (op == pfe_pkg::OP_DIV) begin
                                q   = ml / mr;
                                res = (l[31] ^ r[31]) ? 32'd0 - q : q;
                            end else begin
                                q   = ml % mr;
                                res = l[31] ? 32'd0 - q : q;
                            end
                            calc_push(res);
                        end
                    end else begin
                        case (op)
                            pfe_pkg::OP_ADD: res = l + r;
                            pfe_pkg::OP_SUB: res = l - r;
                            default:         res = l * r;
                        endcase
                        calc_push(res);
                    end
                end
            end
        end
        if (fin) begin
            if (calc_in_num) calc_push(calc_acc);
            st  = calc_err;
            top = 32'd0;
            if (st == pfe_pkg::ST_OK) begin
                if (calc_depth == 0) st = pfe_pkg::ST_UNDER;
                else top = calc_stack[calc_depth-1];
            end
            want_value.push_back(top);
            want_status.push_back(st);
            calc_depth  = 0;
            calc_acc    = 32'd0;
            calc_in_num = 1'b0;
            calc_err    = pfe_pkg::ST_OK;
        end
    endtask

    task automatic put_char(input logic [7:0] c);
        t_char_word w;
        w.code  = c;
        w.last  = 1'b0;
        w.drain = 1'b0;
        pending_chars.push_back(w);
    endtask

    task automatic put_drain();
        t_char_word w;
        w.code  = 8'd0;
        w.last  = 1'b0;
        w.drain = 1'b1;
        pending_chars.push_back(w);
    endtask

    task automatic end_expression();
        t_char_word w;
        w      = pending_chars.pop_back();
        w.last = 1'b1;
        pending_chars.push_back(w);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_char(s[k]);
    endtask

    task automatic put_number(input logic [63:0] v);
        logic [7:0] digs[$];
        if ($urandom_range(0, 9) == 0) put_char(pfe_pkg::CH_0);
        do begin
            digs.push_front(pfe_pkg::CH_0 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[k]) put_char(digs[k]);
    endtask

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 99);
            4:          return 64'd0;
            5:          return $urandom;
            6: begin
                case ($urandom_range(0, 3))
                    0:       return 64'd1;
                    1:       return 64'd2147483647;
                    2:       return 64'd2147483648;
                    default: return 64'd4294967295;
                endcase
            end
            7:          return {$urandom_range(0, 4095), $urandom};
            8:          return $urandom_range(0, 9);
            default:    return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [7:0] rand_op_char();
        case ($urandom_range(0, 4))
            0:       return pfe_pkg::CH_PLUS;
            1:       return pfe_pkg::CH_MINUS;
            2:       return pfe_pkg::CH_STAR;
            3:       return pfe_pkg::CH_SLASH;
            default: return pfe_pkg::CH_PCT;
        endcase
    endfunction

    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= pfe_pkg::CH_0 && c <= pfe_pkg::CH_9) || c == pfe_pkg::CH_PLUS
               || c == pfe_pkg::CH_MINUS || c == pfe_pkg::CH_STAR
               || c == pfe_pkg::CH_SLASH || c == pfe_pkg::CH_PCT);
        return c;
    endfunction

    task automatic put_gap();
        put_char(($urandom_range(0, 4) == 0) ? rand_other() : CH_SPACE);
    endtask

    task automatic put_expression();
        int   kind, steps, depth;
        logic after_num;
        kind      = $urandom_range(0, 99);
        depth     = 0;
        after_num = 1'b0;
        if (kind < 12) begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 3))
                    0:       put_char(pfe_pkg::CH_0 + 8'($urandom_range(0, 9)));
                    1:       put_char(rand_op_char());
                    2:       put_char(CH_SPACE);
                    default: put_char(8'($urandom_range(0, 255)));
                endcase
            end
        end else if (kind < 20) begin
            repeat ($urandom_range(15, 19)) begin
                put_number(rand_operand());
                put_char(CH_SPACE);
            end
            repeat ($urandom_range(0, 3)) put_char(rand_op_char());
        end else if (kind < 26) begin
            put_text("2147483648 0 1-");
            put_char($urandom_range(0, 1) ? pfe_pkg::CH_SLASH : pfe_pkg::CH_PCT);
        end else begin
            steps = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 10);
            repeat (steps) begin
                if (depth < 2 || (depth < DEPTH && $urandom_range(0, 1) == 1)) begin
                    if (after_num) put_gap();
                    put_number(rand_operand());
                    after_num = 1'b1;
                    depth++;
                end else begin
                    if ($urandom_range(0, 2) == 0) put_gap();
                    put_char(rand_op_char());
                    after_num = 1'b0;
                    depth--;
                end
            end
            if ($urandom_range(0, 7) != 0) begin
                while (depth > 1) begin
                    put_char(rand_op_char());
                    depth--;
                end
            end
            if ($urandom_range(0, 9) == 0) put_char(rand_op_char());
            if ($urandom_range(0, 2) == 0) put_gap();
        end
        end_expression();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                calc_char(i_char_code, i_last);
                chars_accepted++;
            end
            if (!(i_valid && !o_ready)) begin
                send_now = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_chars.size() != 0) begin
                    if (pending_chars[0].drain) begin
                        if (want_value.size() == 0) void'(pending_chars.pop_front());
                    end else begin
                        next_word = pending_chars.pop_front();
                        send_now  = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 30);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                i_valid <= send_now;
                if (send_now) begin
                    i_char_code <= next_word.code;
                    i_last      <= next_word.last;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (want_value.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value %0d status %0d",
                                 $signed(o_value), o_status);
                end else begin
                    exp_v = want_value.pop_front();
                    exp_s = want_status.pop_front();
                    if (o_value !== exp_v || o_status !== exp_s) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: value exp %0d got %0d, status exp %0d got %0d",
                                     results_seen, $signed(exp_v), $signed(o_value),
                                     exp_s, o_status);
                    end
                end
            end
            if (chars_accepted >= 200 && !long_hold_done) begin
                hold_left      = 400;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_now = 1'b0;
            end else begin
                if (rx_phase <= 0) begin
                    rx_mode  = $urandom_range(0, 2);
                    rx_phase = $urandom_range(16, 80);
                end
                rx_phase--;
                case (rx_mode)
                    0:       ready_now = 1'b1;
                    1:       ready_now = ($urandom_range(0, 1) == 1);
                    default: ready_now = ($urandom_range(0, 3) == 0);
                endcase
            end
            i_ready <= ready_now;
        end
    end

    initial begin
        logic mid_drain;
        mid_drain = 1'b0;
        put_text("7");
        end_expression();
        put_text("+");
        end_expression();
        put_text("5 0/");
        end_expression();
        put_text("9x4-2*3/7%");
        end_expression();
        put_text("1");
        put_char(8'hFF);
        put_text("2+");
        put_char(8'h00);
        end_expression();
        put_text("1 2");
        end_expression();
        put_drain();
        while (pending_chars.size() < 830) begin
            put_expression();
            if (!mid_drain && pending_chars.size() > 450) begin
                put_drain();
                mid_drain = 1'b1;
            end
        end
        foreach (pending_chars[k]) if (!pending_chars[k].drain) char_total++;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (chars_accepted < char_total) @(posedge i_clk);
        while (want_value.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && want_value.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
